// ===== rtl/particle_kick_with_cell_stats_top_macros.svh =====
// Assertion macros for the particle kick block.
`ifndef PARTICLE_KICK_WITH_CELL_STATS_TOP_MACROS_SVH
`define PARTICLE_KICK_WITH_CELL_STATS_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PK_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define PK_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/pkws_pkg.sv =====
`default_nettype none
package pkws_pkg;
	localparam int unsigned MaxCellParticles = 65536;
	localparam int unsigned CntW = $clog2(MaxCellParticles + 1);
	localparam logic CfgFirst = 1'b0;
	localparam logic CfgSecond = 1'b1;

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] acc_z;
		logic cell_end;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		logic [63:0] mean_square_vel;
		logic [31:0] max_vel_component;
		logic [31:0] max_acc_component;
		logic stats_valid;
	} out_word_t;

	// One classified particle handed from the front to the back.
	typedef struct packed {
		logic signed [31:0] v2_x;
		logic signed [31:0] v2_y;
		logic signed [31:0] v2_z;
		logic [63:0] sum;
		logic [31:0] vpk;
		logic [31:0] apk;
		logic [CntW-1:0] cnt;
		logic last;
	} job_t;

	function automatic logic signed [31:0] sat32(input logic signed [48:0] s);
		if (s > 49'sd2147483647) return 32'sh7fffffff;
		if (s < -49'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-{1'b1, v}) : 32'(v);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/pkws_if.sv =====
`default_nettype none
interface pkws_in_if import pkws_pkg::*; ();
	logic valid;
	logic ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface pkws_out_if import pkws_pkg::*; ();
	logic valid;
	logic ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pkws_front.sv =====
`default_nettype none
module pkws_front import pkws_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic signed [31:0] k1,
	input wire logic signed [31:0] k2,
	pkws_in_if.sink in_ch,
	output logic job_valid,
	output job_t job,
	input wire logic job_ready
);
	// Sequencer: phases 0..2 first kick of x/y/z, 3..5 square and second kick.
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN = 3'b010,
		S_DONE = 3'b100
	} st_t;
	st_t st_q;
	logic [2:0] ph_q;
	in_word_t it_q;
	logic signed [31:0] v1_q [3];
	logic signed [31:0] v2_q [3];
	logic signed [63:0] prod_q;
	logic [63:0] sum_q;
	logic [31:0] vpk_q, apk_q;
	logic [CntW-1:0] cnt_q;
	logic [1:0] ci;
	logic signed [31:0] a_c, v_c, k_c;
	logic [31:0] av;
	logic [63:0] sq;
	logic [64:0] ssum;
	logic signed [48:0] ks;

	assign in_ch.ready = (st_q == S_IDLE);
	assign ci = (ph_q >= 3'd3) ? 2'(ph_q - 3'd3) : ph_q[1:0];

	always_comb begin
		case (ci)
			2'd0: begin a_c = it_q.acc_x; v_c = it_q.vel_x; end
			2'd1: begin a_c = it_q.acc_y; v_c = it_q.vel_y; end
			default: begin a_c = it_q.acc_z; v_c = it_q.vel_z; end
		endcase
		if (ph_q >= 3'd3) v_c = v1_q[ci];
		k_c = (ph_q >= 3'd3) ? k2 : k1;
		ks = 49'(v_c) + 49'(prod_q >>> 16);
		av = abs32(v1_q[ci]);
		sq = 64'(av) * 64'(av);
		ssum = {1'b0, sum_q} + {1'b0, sq};
	end

	// Odd half-steps multiply; a flag splits multiply and add into separate steps.
	logic mul_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ph_q <= '0;
			mul_q <= 1'b0;
			sum_q <= '0;
			vpk_q <= '0;
			apk_q <= '0;
			cnt_q <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						it_q <= in_ch.data;
						st_q <= S_RUN;
						ph_q <= '0;
						mul_q <= 1'b1;
					end
				end
				S_RUN: begin
					if (mul_q) begin
						prod_q <= 64'(a_c) * 64'(k_c);
						mul_q <= 1'b0;
					end else begin
						mul_q <= 1'b1;
						if (ph_q < 3'd3) begin
							v1_q[ci] <= sat32(ks);
							if (abs32(a_c) > apk_q) apk_q <= abs32(a_c);
						end else begin
							v2_q[ci] <= sat32(ks);
							sum_q <= ssum[64] ? '1 : ssum[63:0];
							if (av > vpk_q) vpk_q <= av;
						end
						if (ph_q == 3'd5) begin
							st_q <= S_DONE;
							if (cnt_q < CntW'(MaxCellParticles)) cnt_q <= cnt_q + 1'b1;
						end
						ph_q <= ph_q + 3'd1;
					end
				end
				S_DONE: begin
					if (job_ready) begin
						st_q <= S_IDLE;
						if (it_q.cell_end) begin
							sum_q <= '0;
							vpk_q <= '0;
							apk_q <= '0;
							cnt_q <= '0;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign job_valid = (st_q == S_DONE);
	always_comb begin
		job.v2_x = v2_q[0];
		job.v2_y = v2_q[1];
		job.v2_z = v2_q[2];
		job.sum = sum_q;
		job.vpk = vpk_q;
		job.apk = apk_q;
		job.cnt = cnt_q;
		job.last = it_q.cell_end;
	end
endmodule
`default_nettype wire

// ===== rtl/pkws_queue.sv =====
`default_nettype none
module pkws_queue import pkws_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire job_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output job_t rd_data
);
	job_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pkws_back.sv =====
`default_nettype none
module pkws_back import pkws_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_ready,
	input wire job_t job,
	pkws_out_if.source out_ch
);
	// Restoring divider, one quotient bit a cycle, for the cell mean.
	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV = 3'b010,
		B_OUT = 3'b100
	} bst_t;
	bst_t st_q;
	job_t j_q;
	logic [63:0] quo_q;
	logic [CntW-1:0] rem_q;
	logic [5:0] bit_q;
	logic [CntW:0] trial;

	assign job_ready = (st_q == B_IDLE);
	assign trial = {rem_q, quo_q[63]} - {1'b0, j_q.cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (job_valid) begin
						j_q <= job;
						quo_q <= job.sum;
						rem_q <= '0;
						bit_q <= '0;
						st_q <= job.last ? B_DIV : B_OUT;
					end
				end
				B_DIV: begin
					if (!trial[CntW]) begin
						rem_q <= trial[CntW-1:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[CntW-2:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd63) st_q <= B_OUT;
				end
				B_OUT: begin
					if (out_ch.ready) st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign out_ch.valid = (st_q == B_OUT);
	always_comb begin
		out_ch.data.new_vel_x = j_q.v2_x;
		out_ch.data.new_vel_y = j_q.v2_y;
		out_ch.data.new_vel_z = j_q.v2_z;
		out_ch.data.mean_square_vel = j_q.last ? quo_q : '0;
		out_ch.data.max_vel_component = j_q.last ? j_q.vpk : '0;
		out_ch.data.max_acc_component = j_q.last ? j_q.apk : '0;
		out_ch.data.stats_valid = j_q.last;
	end
endmodule
`default_nettype wire

// ===== rtl/particle_kick_with_cell_stats_top.sv =====
`default_nettype none
// Leapfrog velocity kick with per-cell statistics. Each input word is one
// particle; each yields exactly one output word with the velocity after both
// half kicks, and the cell's last particle also carries the mean square
// velocity and the velocity and acceleration peaks. The front accepts the
// word, then one shared 32x32 multiplier serves all six kick products
// (multiply and add in separate cycles), then the front hands the result to
// the queue, waiting while it is full, and only then takes the next word. A
// two-entry queue lets the back work on its own; the back adds a bit-serial
// divide on the last particle of a cell, overlapped with the next particles
// in the front. Configuration writes must only happen while the block is
// idle.
`include "particle_kick_with_cell_stats_top_macros.svh"
module particle_kick_with_cell_stats_top import pkws_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [31:0] cfg_data,
	pkws_in_if.sink in_ch,
	pkws_out_if.source out_ch
);
	logic signed [31:0] k1_q, k2_q;
	logic f_valid, f_ready, q_valid, q_ready;
	job_t f_job, q_job;

	// Kick factors, signed Q16.16.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgFirst: k1_q <= cfg_data;
				CfgSecond: k2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pkws_front u_front (
		.clk, .arst_n, .k1(k1_q), .k2(k2_q), .in_ch,
		.job_valid(f_valid), .job(f_job), .job_ready(f_ready)
	);

	pkws_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);

	pkws_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job_ready(q_ready), .job(q_job), .out_ch
	);

	// A word without statistics carries zero statistics.
	`PK_ASSERT_IMP(a_zero_stats, out_ch.valid && !out_ch.data.stats_valid,
		out_ch.data.mean_square_vel == 64'd0 && out_ch.data.max_vel_component == 32'd0)
	// The mean never exceeds the accumulated sum.
	`PK_ASSERT_IMP(a_mean_le_sum, out_ch.valid && out_ch.data.stats_valid,
		out_ch.data.mean_square_vel <= u_back.j_q.sum)
	// A stalled output word holds.
	`PK_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))
endmodule
`default_nettype wire
